FILE: rtl/ulcc_pkg.sv
// Shared types, constants and the code point length decode for the UTF-8 line clamp.
package ulcc_pkg;

   // Bytes that always survive and restart the per-line count.
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // Lead byte class masks and patterns.
   localparam logic [7:0] MASK_CONT  = 8'hC0;
   localparam logic [7:0] PAT_CONT   = 8'h80;
   localparam logic [7:0] MASK_LEAD2 = 8'hE0;
   localparam logic [7:0] PAT_LEAD2  = 8'hC0;
   localparam logic [7:0] MASK_LEAD3 = 8'hF0;
   localparam logic [7:0] PAT_LEAD3  = 8'hE0;
   localparam logic [7:0] MASK_LEAD4 = 8'hF8;
   localparam logic [7:0] PAT_LEAD4  = 8'hF0;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLAMP_ENABLE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CODEPOINTS = 1'd1;
   localparam logic        CLAMP_ENABLE_RESET = 1'b1;
   localparam logic [15:0] MAX_CODEPOINTS_RESET = 16'd4096;
   localparam logic [15:0] COUNT_SATURATED = 16'hFFFF;

   // Window of undecided bytes plus the byte just taken in.
   localparam int WINDOW = 4;

   typedef logic [WINDOW-1:0][7:0] window_type;

   // Line state carried from one request to the next.
   typedef struct packed {
      window_type  held_bytes;
      logic [1:0]  held_count;
      logic [15:0] line_count;
   } line_state_type;

   // One result leaving the block.
   typedef struct packed {
      logic [7:0] byte_value;
      logic       kept;
      logic       final_of_text;
      logic       run_last;
   } result_type;

   typedef result_type [WINDOW-1:0] result_bundle_type;

   function automatic logic is_cont(input logic [7:0] b);
      return (b & MASK_CONT) == PAT_CONT;
   endfunction

   // Length of the code point starting at pos, or zero while still undecided.
   function automatic logic [2:0] head_len(input window_type b, input logic [2:0] pos,
                                           input logic [2:0] total, input logic flush);
      logic [7:0] lead;
      logic [2:0] need;
      logic [2:0] idx;
      logic [2:0] len;
      logic       done;
      lead = b[pos[1:0]];
      need = 3'd0;
      len  = 3'd1;
      done = 1'b0;
      if (lead >= 8'h80) begin
         if ((lead & MASK_LEAD2) == PAT_LEAD2) need = 3'd1;
         else if ((lead & MASK_LEAD3) == PAT_LEAD3) need = 3'd2;
         else if ((lead & MASK_LEAD4) == PAT_LEAD4) need = 3'd3;
      end
      // Check up to three continuation positions in turn.
      for (int i = 1; i <= 3; i++) begin
         idx = pos + 3'(i);
         if (!done && 3'(i) <= need) begin
            if (idx >= total) begin
               len  = flush ? 3'd1 : 3'd0;
               done = 1'b1;
            end else if (!is_cont(b[idx[1:0]])) begin
               len  = 3'd1;
               done = 1'b1;
            end
         end
      end
      if (!done) len = need + 3'd1;
      return len;
   endfunction

endpackage

FILE: rtl/utf8_line_codepoint_clamp.sv
// Top level of the per-line UTF-8 code point clamp with its stream ports and registers.
//
// Bytes of a text enter one request per cycle while req_tready is high. A lead
// byte is held until its continuation bytes are all present or a non-continuation
// byte shows that it stands alone, so each byte leaves with its kept flag up to
// three requests later; the request with tlast flushes everything held and starts
// a new text. A request is registered, decided in one pass, and its zero to four
// results are appended behind whatever still waits in a four-entry result
// register that drains one result per cycle while rsp_tready is high. The
// registered request moves on in any cycle in which its results fit beside those
// left after that cycle's output beat. Every byte yields exactly one result, so
// with rsp_tready held high the block takes one byte in every cycle. The first
// result of a request leaves only after passing the input register and the result
// register. rsp_tready reaches req_tready through combinational logic.
// The configuration port is always ready; write it only while the block is idle.
module utf8_line_codepoint_clamp (
   input  logic        clock,
   input  logic        reset,
   // Requests: text bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // text_end
   // Results: bytes with their kept flags.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] byte_value
   output logic [1:0]  rsp_tuser,   // [0] kept, [1] run_last
   output logic        rsp_tlast,   // final_of_text
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ulcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_end_ff, in_end_in;

   logic        clamp_enable_ff, clamp_enable_in;
   logic [15:0] max_codepoints_ff, max_codepoints_in;

   ulcc_pkg::window_type        held_bytes_ff, held_bytes_in;
   logic [1:0]                  held_count_ff, held_count_in;
   logic [15:0]                 line_count_ff, line_count_in;

   ulcc_pkg::result_bundle_type slots_ff, slots_in;
   logic [2:0]                  slot_count_ff, slot_count_in;

   ulcc_pkg::line_state_type    state_cur, state_nxt;
   ulcc_pkg::result_bundle_type step_results;
   logic [2:0]                  step_count;
   logic                        slots_free;
   logic                        load;
   logic                        rsp_fire;
   ulcc_pkg::result_bundle_type slots_left;
   logic [2:0]                  slot_base;
   logic [2:0]                  slot_pos;

   assign state_cur.held_bytes = held_bytes_ff;
   assign state_cur.held_count = held_count_ff;
   assign state_cur.line_count = line_count_ff;

   ulcc_step u_step (
      .state_cur      (state_cur),
      .data_byte      (in_byte_ff),
      .text_end       (in_end_ff),
      .clamp_enable   (clamp_enable_ff),
      .max_codepoints (max_codepoints_ff),
      .state_nxt      (state_nxt),
      .results        (step_results),
      .result_count   (step_count)
   );

   // Handshakes: the registered request moves on once its results fit in the result register.
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign slot_base  = slot_count_ff - {2'b00, rsp_fire};
   assign slots_free = ({1'b0, slot_base} + {1'b0, step_count}) <= 4'd4;
   assign load       = in_valid_ff && slots_free;
   assign req_tready = !in_valid_ff || load;
   assign csr_ready  = 1'b1;

   // Result port shows the head of the result register.
   assign rsp_tvalid = (slot_count_ff != 3'd0);
   assign rsp_tdata  = slots_ff[0].byte_value;
   assign rsp_tuser  = {slots_ff[0].run_last, slots_ff[0].kept};
   assign rsp_tlast  = slots_ff[0].final_of_text;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_end_in   = req_tlast;
      end
   end

   // Line state advances when a request is decided.
   always_comb begin
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      line_count_in = line_count_ff;
      if (load) begin
         held_bytes_in = state_nxt.held_bytes;
         held_count_in = state_nxt.held_count;
         line_count_in = state_nxt.line_count;
      end
   end

   // Result register: shift one result out when it leaves, then append a whole run behind what is left.
   always_comb begin
      slots_left = slots_ff;
      if (rsp_fire) begin
         for (int j = 0; j < ulcc_pkg::WINDOW - 1; j++) slots_left[j] = slots_ff[j + 1];
      end
      slots_in      = slots_left;
      slot_count_in = slot_base;
      slot_pos      = 3'd0;
      if (load) begin
         for (int j = 0; j < ulcc_pkg::WINDOW; j++) begin
            slot_pos = 3'(j) - slot_base;
            if (3'(j) >= slot_base) slots_in[j] = step_results[slot_pos[1:0]];
         end
         slot_count_in = slot_base + step_count;
      end
   end

   // Configuration register decode.
   always_comb begin
      clamp_enable_in   = clamp_enable_ff;
      max_codepoints_in = max_codepoints_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ulcc_pkg::CSR_CLAMP_ENABLE:   clamp_enable_in   = csr_wdata[0];
            ulcc_pkg::CSR_MAX_CODEPOINTS: max_codepoints_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         held_count_ff     <= 2'd0;
         line_count_ff     <= 16'd0;
         slot_count_ff     <= 3'd0;
         clamp_enable_ff   <= ulcc_pkg::CLAMP_ENABLE_RESET;
         max_codepoints_ff <= ulcc_pkg::MAX_CODEPOINTS_RESET;
      end else begin
         in_valid_ff       <= in_valid_in;
         held_count_ff     <= held_count_in;
         line_count_ff     <= line_count_in;
         slot_count_ff     <= slot_count_in;
         clamp_enable_ff   <= clamp_enable_in;
         max_codepoints_ff <= max_codepoints_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_end_ff     <= in_end_in;
      held_bytes_ff <= held_bytes_in;
      slots_ff      <= slots_in;
   end

endmodule

FILE: rtl/ulcc_step.sv
// Single-pass decision logic: appends one byte, decides complete code points, updates the line.
module ulcc_step (
   input  ulcc_pkg::line_state_type    state_cur,
   input  logic [7:0]                  data_byte,
   input  logic                        text_end,
   input  logic                        clamp_enable,
   input  logic [15:0]                 max_codepoints,
   output ulcc_pkg::line_state_type    state_nxt,
   output ulcc_pkg::result_bundle_type results,
   output logic [2:0]                  result_count
);

   ulcc_pkg::window_type bytes_all;
   logic [2:0]  total;
   logic [2:0]  pos;
   logic [2:0]  len;
   logic [15:0] count;
   logic        stop;
   logic        keep_cp;
   logic [7:0]  lead;
   logic [ulcc_pkg::WINDOW-1:0] kept_flags;
   logic [2:0]  shift_idx;

   // Walk the window, deciding at most one code point per position.
   always_comb begin
      bytes_all = state_cur.held_bytes;
      bytes_all[state_cur.held_count] = data_byte;
      total      = {1'b0, state_cur.held_count} + 3'd1;
      pos        = 3'd0;
      count      = state_cur.line_count;
      stop       = 1'b0;
      kept_flags = '0;
      len        = 3'd0;
      keep_cp    = 1'b0;
      lead       = 8'h00;
      for (int d = 0; d < ulcc_pkg::WINDOW; d++) begin
         if (!stop && pos < total) begin
            len = ulcc_pkg::head_len(bytes_all, pos, total, text_end);
            if (len == 3'd0) begin
               stop = 1'b1;
            end else begin
               lead = bytes_all[pos[1:0]];
               if (lead == ulcc_pkg::CHAR_LF || lead == ulcc_pkg::CHAR_CR) begin
                  keep_cp = 1'b1;
                  count   = 16'd0;
               end else begin
                  keep_cp = !clamp_enable || (count < max_codepoints);
                  if (count != ulcc_pkg::COUNT_SATURATED) count = count + 16'd1;
               end
               for (int k = 0; k < ulcc_pkg::WINDOW; k++) begin
                  if (3'(k) >= pos && 3'(k) < pos + len) kept_flags[k] = keep_cp;
               end
               pos = pos + len;
            end
         end
      end
   end

   // Decided bytes leave in order; the last one closes the run.
   always_comb begin
      for (int k = 0; k < ulcc_pkg::WINDOW; k++) begin
         results[k].byte_value    = bytes_all[k];
         results[k].kept          = kept_flags[k];
         results[k].run_last      = (3'(k) + 3'd1 == pos);
         results[k].final_of_text = text_end && (3'(k) + 3'd1 == pos);
      end
      result_count = pos;
   end

   // Undecided bytes move to the front of the window.
   always_comb begin
      state_nxt.held_bytes = bytes_all;
      for (int j = 0; j < ulcc_pkg::WINDOW; j++) begin
         shift_idx = 3'(j) + pos;
         if (shift_idx < 3'(ulcc_pkg::WINDOW)) state_nxt.held_bytes[j] = bytes_all[shift_idx[1:0]];
      end
      shift_idx            = total - pos;
      state_nxt.held_count = text_end ? 2'd0 : shift_idx[1:0];
      state_nxt.line_count = text_end ? 16'd0 : count;
   end

endmodule
